FILE: hdl/battery_percent_gauge_defines.svh
// Assertion macros for the battery percent gauge.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef BATTERY_PERCENT_GAUGE_DEFINES_SVH
`define BATTERY_PERCENT_GAUGE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define BPG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bpg_pkg.sv
// Shared types, constants and the discharge curve table of the battery gauge.
// No dependencies.
package bpg_pkg;

  // Field widths
  localparam int unsigned SampleW   = 12;
  localparam int unsigned ScaleW    = 3;
  localparam int unsigned ThrW      = 14;
  localparam int unsigned OffsetW   = 11;
  localparam int unsigned PctW      = 7;
  localparam int unsigned StateW    = 2;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 14;
  localparam int unsigned ScaledW   = SampleW + ScaleW;
  localparam int unsigned DiffW     = ScaledW + 1;
  localparam int unsigned CurveIdxW = 8;

  // Curve constants
  localparam int unsigned CurveTop     = 4160;
  localparam int unsigned CurveBottom  = 3580;
  localparam int unsigned CurveStep    = 4;
  localparam int unsigned InitBias     = 5;
  localparam int unsigned FullPercent  = 100;
  localparam int unsigned CurveEntries = 146;
  localparam int unsigned MaxEntry     = FullPercent + InitBias;

  // Register reset values
  localparam logic [ScaleW-1:0]         ScaleRst  = 3'd2;
  localparam logic [ThrW-1:0]           ChargeRst = 14'd4300;
  localparam logic [ThrW-1:0]           FullRst   = 14'd4200;
  localparam logic signed [OffsetW-1:0] OffsetRst = 11'sd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ADC_SCALE        = 2'd0,
    REG_CHARGE_THRESHOLD = 2'd1,
    REG_FULL_THRESHOLD   = 2'd2,
    REG_CURVE_OFFSET     = 2'd3
  } cfg_reg_e;

  typedef enum logic [StateW-1:0] {
    CHG_NORMAL   = 2'd0,
    CHG_CHARGING = 2'd1,
    CHG_FULL     = 2'd2
  } chg_state_e;

  // Discharge curve, one entry per 4 counts from 3580 up to 4160
  localparam logic [PctW-1:0] CURVE_ROM [CurveEntries] = '{
    7'd0,  7'd1,  7'd1,  7'd1,  7'd2,  7'd2,  7'd3,  7'd3,  7'd3,  7'd3,
    7'd4,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd8,  7'd9,  7'd10, 7'd11,
    7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd22,
    7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29, 7'd30, 7'd35, 7'd36,
    7'd37, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd46,
    7'd47, 7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd55,
    7'd56, 7'd57, 7'd58, 7'd59, 7'd60, 7'd60, 7'd61, 7'd61, 7'd62, 7'd62,
    7'd63, 7'd64, 7'd65, 7'd65, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70,
    7'd70, 7'd70, 7'd71, 7'd71, 7'd72, 7'd73, 7'd73, 7'd74, 7'd75, 7'd75,
    7'd76, 7'd77, 7'd77, 7'd78, 7'd78, 7'd79, 7'd79, 7'd80, 7'd80, 7'd80,
    7'd80, 7'd81, 7'd82, 7'd82, 7'd82, 7'd83, 7'd83, 7'd83, 7'd84, 7'd84,
    7'd84, 7'd85, 7'd85, 7'd85, 7'd86, 7'd86, 7'd87, 7'd87, 7'd87, 7'd88,
    7'd88, 7'd89, 7'd89, 7'd89, 7'd90, 7'd90, 7'd90, 7'd90, 7'd91, 7'd92,
    7'd92, 7'd93, 7'd93, 7'd94, 7'd95, 7'd95, 7'd96, 7'd96, 7'd96, 7'd97,
    7'd97, 7'd98, 7'd99, 7'd99, 7'd99, 7'd100
  };

endpackage

FILE: hdl/bpg_in_if.sv
// Sample request channel: valid/ready handshake carrying one converter sample.
// Depends on bpg_pkg.
interface bpg_in_if;
  logic                        valid;
  logic                        ready;
  logic [bpg_pkg::SampleW-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

FILE: hdl/bpg_out_if.sv
// Result request channel: valid/ready handshake carrying level and charge state.
// Depends on bpg_pkg.
interface bpg_out_if;
  logic                       valid;
  logic                       ready;
  logic [bpg_pkg::PctW-1:0]   level_percent;
  logic [bpg_pkg::StateW-1:0] charge_state;

  modport source (output valid, output level_percent, output charge_state, input ready);
  modport sink (input valid, input level_percent, input charge_state, output ready);
endinterface

FILE: hdl/battery_percent_gauge.sv
// Battery percent gauge top level: sample scaling, curve lookup, ring average in RAM.
// Depends on bpg_pkg, bpg_in_if, bpg_out_if, bpg_ram and the defines header.
//
//   channel    dir  handshake            payload
//   sample_i   in   valid/ready          adc_sample[11:0]
//   result_o   out  valid/ready          level_percent[6:0], charge_state[1:0]
//   cfg        in   cfg_we_i (no wait)   cfg_idx_i[1:0], cfg_wdata_i[13:0]
//
// One request per cycle while the result side does not stall; a taken request
// is registered into the update stage, and the update stage then loads the
// output register (lookup stage, then history update stage feeding the output register).
// The history RAM does one read and one write per cycle; a write to the entry
// being read in the same cycle is forwarded.
// Reset takes effect at once: per-entry valid bits stand in for a clearing pass.
// A held result stalls the update stage; the input keeps taking requests until
// the update stage is also full.
`include "battery_percent_gauge_defines.svh"

module battery_percent_gauge #(
  parameter int unsigned HISTORY_DEPTH = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  bpg_in_if.sink                        sample_i,
  bpg_out_if.source                     result_o
);

  localparam int unsigned PtrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned SumW = $clog2(HISTORY_DEPTH * bpg_pkg::MaxEntry + 1);

  // Reciprocal of the history depth for the average, exact over the sum range
  localparam int unsigned RecipK = SumW + $clog2(HISTORY_DEPTH);
  localparam int unsigned RecipW = RecipK + 1;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'((2 ** RecipK + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

  localparam int unsigned PctW = bpg_pkg::PctW;

  // Configuration registers
  logic [bpg_pkg::ScaleW-1:0]         scale_q;
  logic [bpg_pkg::ThrW-1:0]           chg_thr_q;
  logic [bpg_pkg::ThrW-1:0]           full_thr_q;
  logic signed [bpg_pkg::OffsetW-1:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= bpg_pkg::ScaleRst;
      chg_thr_q  <= bpg_pkg::ChargeRst;
      full_thr_q <= bpg_pkg::FullRst;
      offset_q   <= bpg_pkg::OffsetRst;
    end else if (cfg_we_i) begin
      case (bpg_pkg::cfg_reg_e'(cfg_idx_i))
        bpg_pkg::REG_ADC_SCALE:        scale_q    <= cfg_wdata_i[bpg_pkg::ScaleW-1:0];
        bpg_pkg::REG_CHARGE_THRESHOLD: chg_thr_q  <= cfg_wdata_i;
        bpg_pkg::REG_FULL_THRESHOLD:   full_thr_q <= cfg_wdata_i;
        bpg_pkg::REG_CURVE_OFFSET:     offset_q   <= $signed(cfg_wdata_i[bpg_pkg::OffsetW-1:0]);
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic s1_valid_q;
  logic s1_fire;
  logic out_valid_q;
  logic accept;

  assign s1_fire        = s1_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !s1_valid_q || s1_fire;
  assign accept         = sample_i.valid && sample_i.ready;

  // Lookup stage: scale, classify, map through the curve
  logic [bpg_pkg::ScaledW-1:0]      scaled;
  logic signed [bpg_pkg::DiffW-1:0] diff;
  logic [bpg_pkg::DiffW-1:0]        diff_rnd;
  logic [bpg_pkg::DiffW-1:0]        curve_ofs;
  logic [bpg_pkg::CurveIdxW-1:0]    curve_idx;
  logic [PctW-1:0]                  pct_a;
  bpg_pkg::chg_state_e              state_a;

  always_comb begin
    scaled = bpg_pkg::ScaledW'(sample_i.adc_sample) * bpg_pkg::ScaledW'(scale_q);
    if (scaled > bpg_pkg::ScaledW'(chg_thr_q)) begin
      state_a = bpg_pkg::CHG_CHARGING;
    end else if (scaled > bpg_pkg::ScaledW'(full_thr_q)) begin
      state_a = bpg_pkg::CHG_FULL;
    end else begin
      state_a = bpg_pkg::CHG_NORMAL;
    end

    diff      = $signed({1'b0, scaled}) - bpg_pkg::DiffW'(offset_q);
    // round down to a curve step
    diff_rnd  = {diff[bpg_pkg::DiffW-1:2], 2'b00};
    curve_ofs = diff_rnd - bpg_pkg::DiffW'(bpg_pkg::CurveBottom);
    curve_idx = bpg_pkg::CurveIdxW'(curve_ofs / bpg_pkg::CurveStep);

    if (diff[bpg_pkg::DiffW-1]) begin
      pct_a = '0;
    end else if (diff_rnd > bpg_pkg::DiffW'(bpg_pkg::CurveTop)) begin
      pct_a = PctW'(bpg_pkg::FullPercent);
    end else if (diff_rnd < bpg_pkg::DiffW'(bpg_pkg::CurveBottom)) begin
      pct_a = '0;
    end else begin
      pct_a = bpg_pkg::CURVE_ROM[curve_idx];
    end
  end

  // History pointer advances on normal samples only, in request order
  logic [PtrW-1:0] ptr_q;
  logic            normal_a;

  assign normal_a = (state_a == bpg_pkg::CHG_NORMAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (accept && normal_a) begin
      if (ptr_q == PtrW'(HISTORY_DEPTH - 1)) begin
        ptr_q <= '0;
      end else begin
        ptr_q <= ptr_q + PtrW'(1);
      end
    end
  end

  // Update-stage registers
  bpg_pkg::chg_state_e s1_state_q;
  logic [PctW-1:0]     s1_pct_q;
  logic [PtrW-1:0]     s1_addr_q;
  logic                s1_byp_hit_q;
  logic [PctW-1:0]     s1_byp_data_q;
  logic                s1_normal;
  logic                hist_we;
  logic                byp_hit_d;

  assign s1_normal = (s1_state_q == bpg_pkg::CHG_NORMAL);
  assign hist_we   = s1_fire && s1_normal;
  // write from the update stage to the entry being read now
  assign byp_hit_d = hist_we && (s1_addr_q == ptr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_state_q    <= state_a;
      s1_pct_q      <= pct_a;
      s1_addr_q     <= ptr_q;
      s1_byp_hit_q  <= byp_hit_d;
      s1_byp_data_q <= s1_pct_q;
    end
  end

  // History RAM
  logic [PctW-1:0] hist_rdata;

  bpg_ram #(
    .Width (PctW),
    .Depth (HISTORY_DEPTH),
    .AddrW (PtrW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_pct_q),
    .re_i    (accept),
    .raddr_i (ptr_q),
    .rdata_o (hist_rdata)
  );

  // Gauge state: running sum, entry valid bits, fill value after re-arm
  logic [HISTORY_DEPTH-1:0] valid_q;
  logic [PctW-1:0]          fill_q;
  logic [SumW-1:0]          sum_q;
  logic                     rearm_q;
  logic [PctW-1:0]          last_q;
  logic [PctW-1:0]          reported_q;

  logic [PctW-1:0]  old_ent;
  logic [PctW-1:0]  bias;
  logic [SumW-1:0]  sum_new;
  logic [ProdW-1:0] avg_prod;
  logic [SumW-1:0]  avg_full;
  logic [PctW-1:0]  avg;
  logic [PctW-1:0]  last_eff;
  logic             upd;
  logic [PctW-1:0]  level_s1;

  always_comb begin
    if (s1_byp_hit_q) begin
      old_ent = s1_byp_data_q;
    end else if (valid_q[s1_addr_q]) begin
      old_ent = hist_rdata;
    end else begin
      old_ent = fill_q;
    end

    bias = s1_pct_q + PctW'(bpg_pkg::InitBias);

    // re-arm fills every entry with bias, then this entry takes pct
    if (rearm_q) begin
      sum_new = SumW'((HISTORY_DEPTH - 1) * int'(bias) + int'(s1_pct_q));
    end else begin
      sum_new = sum_q - SumW'(old_ent) + SumW'(s1_pct_q);
    end

    // divide by the depth through the reciprocal
    avg_prod = ProdW'(sum_new) * ProdW'(Recip);
    avg_full = SumW'(avg_prod >> RecipK);
    if (avg_full > SumW'(bpg_pkg::FullPercent)) begin
      avg = PctW'(bpg_pkg::FullPercent);
    end else begin
      avg = avg_full[PctW-1:0];
    end

    last_eff = rearm_q ? bias : last_q;
    upd      = (avg < last_eff);

    if (s1_normal && upd) begin
      level_s1 = avg;
    end else begin
      level_s1 = reported_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      fill_q     <= '0;
      sum_q      <= '0;
      rearm_q    <= 1'b1;
      last_q     <= '0;
      reported_q <= '0;
    end else if (s1_fire) begin
      if (s1_normal) begin
        sum_q   <= sum_new;
        rearm_q <= 1'b0;
        if (rearm_q) begin
          valid_q <= HISTORY_DEPTH'(1) << s1_addr_q;
          fill_q  <= bias;
        end else begin
          valid_q[s1_addr_q] <= 1'b1;
        end
        last_q <= upd ? avg : last_eff;
        if (upd) begin
          reported_q <= avg;
        end
      end else begin
        rearm_q <= 1'b1;
      end
    end
  end

  // Output register
  logic [PctW-1:0]            out_level_q;
  logic [bpg_pkg::StateW-1:0] out_state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_level_q <= level_s1;
      out_state_q <= s1_state_q;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.level_percent = out_level_q;
  assign result_o.charge_state  = out_state_q;

  // Checks
  `BPG_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_fire, s1_valid_q && $stable(s1_addr_q) && $stable(s1_pct_q), "update stage lost its request while stalled")
  `BPG_ASSERT_IMPL(a_level_range, out_valid_q, out_level_q <= PctW'(bpg_pkg::FullPercent), "reported level above full scale")
  `BPG_ASSERT_IMPL(a_sum_bound, 1'b1, sum_q <= SumW'(HISTORY_DEPTH * bpg_pkg::MaxEntry), "history sum out of range")

endmodule

FILE: hdl/bpg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
